@@ src/pfcls_pkg.sv @@
// ----------------------------------------------------------------------------
// PFC line supervisor package
// Shared types and constants: beat payloads, configuration set, mode codes.
// ----------------------------------------------------------------------------
package pfcls_pkg;

    // Width of the configuration write data and of the register index.
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_UNDER_TRIP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OVER_TRIP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UNDER_RECOVER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OVER_RECOVER  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MIN    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = 3'd7;

    // Reset values of the configuration registers.
    localparam logic [15:0] RST_LEVEL_LOW  = 16'h0000;
    localparam logic [15:0] RST_LEVEL_HIGH = 16'hFFFF;
    localparam logic [7:0]  RST_DEBOUNCE   = 8'd40;

    // Saturation value of the bad tick counter.
    localparam logic [7:0] BAD_COUNT_MAX = 8'hFF;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_NORMAL = 2'd1,
        MODE_FAULT  = 2'd2
    } mode_t;

    typedef struct packed {
        logic [15:0] under_trip_level;
        logic [15:0] over_trip_level;
        logic [15:0] under_recover_level;
        logic [15:0] over_recover_level;
        logic [15:0] start_window_low;
        logic [15:0] start_window_high;
        logic [15:0] output_min_level;
        logic [7:0]  debounce_limit;
    } cfg_t;

    typedef struct packed {
        logic [15:0] rms_input_voltage;
        logic [15:0] output_voltage;
        logic        any_fault_active;
        logic        fault_trip;
    } in_item_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       under_tripped;
        logic       over_tripped;
        logic       pwm_off;
        logic       relay_clear;
        logic       run_values_reset;
        logic       fault_values_reset;
        logic       reference_capture;
        logic       normal_switching_request;
    } out_item_t;

endpackage

@@ src/pfcls_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// PFC line supervisor configuration registers
// Holds the thresholds and debounce limit written through the write port.
// ----------------------------------------------------------------------------
module pfcls_cfg_regs
    import pfcls_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_UNDER_TRIP:    cfg_next.under_trip_level    = cfg_data;
                REG_OVER_TRIP:     cfg_next.over_trip_level     = cfg_data;
                REG_UNDER_RECOVER: cfg_next.under_recover_level = cfg_data;
                REG_OVER_RECOVER:  cfg_next.over_recover_level  = cfg_data;
                REG_WINDOW_LOW:    cfg_next.start_window_low    = cfg_data;
                REG_WINDOW_HIGH:   cfg_next.start_window_high   = cfg_data;
                REG_OUTPUT_MIN:    cfg_next.output_min_level    = cfg_data;
                REG_DEBOUNCE:      cfg_next.debounce_limit      = cfg_data[7:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.under_trip_level    <= RST_LEVEL_LOW;
            cfg_reg.over_trip_level     <= RST_LEVEL_HIGH;
            cfg_reg.under_recover_level <= RST_LEVEL_LOW;
            cfg_reg.over_recover_level  <= RST_LEVEL_HIGH;
            cfg_reg.start_window_low    <= RST_LEVEL_LOW;
            cfg_reg.start_window_high   <= RST_LEVEL_HIGH;
            cfg_reg.output_min_level    <= RST_LEVEL_LOW;
            cfg_reg.debounce_limit      <= RST_DEBOUNCE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/pfcls_fsm.sv @@
// ----------------------------------------------------------------------------
// PFC line supervisor state machine
// Mode, trip flags and debounce counter, advanced once per control tick.
// ----------------------------------------------------------------------------
module pfcls_fsm
    import pfcls_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step_en,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t res
);

    mode_t       mode_reg;
    mode_t       mode_next;
    logic        under_reg;
    logic        under_next;
    logic        over_reg;
    logic        over_next;
    logic [7:0]  cnt_reg;
    logic [7:0]  cnt_next;

    logic        vout_ok;
    logic        rms_low;
    logic        rms_high;
    logic        vout_low;
    logic [7:0]  cnt_inc;
    mode_t       mode_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            under_reg <= 1'b0;
            over_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (step_en)
        begin
            mode_reg  <= mode_next;
            under_reg <= under_next;
            over_reg  <= over_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign vout_ok  = item.output_voltage > cfg.output_min_level;
    assign vout_low = item.output_voltage < cfg.output_min_level;
    assign rms_low  = item.rms_input_voltage < cfg.under_trip_level;
    assign rms_high = item.rms_input_voltage > cfg.over_trip_level;
    assign cnt_inc  = (cnt_reg != BAD_COUNT_MAX) ? cnt_reg + 8'd1 : cnt_reg;

    always_comb
    begin
        // A forced fault takes effect before this tick's step.
        mode_eff   = item.fault_trip ? MODE_FAULT : mode_reg;
        mode_next  = mode_eff;
        under_next = under_reg;
        over_next  = over_reg;
        cnt_next   = cnt_reg;
        res        = '0;

        unique case (mode_eff)
            MODE_IDLE:
            begin
                res.relay_clear = 1'b1;
                if (under_reg)
                begin
                    if (item.rms_input_voltage > cfg.under_recover_level &&
                        item.rms_input_voltage < cfg.start_window_high && vout_ok)
                    begin
                        mode_next                    = MODE_NORMAL;
                        res.normal_switching_request = 1'b1;
                        under_next                   = 1'b0;
                    end
                end
                else if (over_reg)
                begin
                    if (item.rms_input_voltage > cfg.start_window_low &&
                        item.rms_input_voltage < cfg.over_recover_level && vout_ok)
                    begin
                        mode_next                    = MODE_NORMAL;
                        res.normal_switching_request = 1'b1;
                        over_next                    = 1'b0;
                    end
                end
                else if (item.rms_input_voltage > cfg.start_window_low &&
                         item.rms_input_voltage < cfg.start_window_high && vout_ok)
                begin
                    mode_next             = MODE_NORMAL;
                    res.reference_capture = 1'b1;
                end
            end
            MODE_NORMAL:
            begin
                if (rms_low || rms_high || vout_low)
                begin
                    cnt_next = cnt_inc;
                    if (cnt_inc > cfg.debounce_limit)
                    begin
                        // Overvoltage wins; an output-only trip sets no flag.
                        if (rms_high)
                        begin
                            over_next = 1'b1;
                        end
                        else if (rms_low)
                        begin
                            under_next = 1'b1;
                        end
                        mode_next            = MODE_IDLE;
                        res.pwm_off          = 1'b1;
                        res.run_values_reset = 1'b1;
                        res.relay_clear      = 1'b1;
                        cnt_next             = '0;
                    end
                end
                else
                begin
                    cnt_next = '0;
                end
            end
            MODE_FAULT:
            begin
                res.relay_clear = 1'b1;
                res.pwm_off     = 1'b1;
                if (!item.any_fault_active)
                begin
                    mode_next              = MODE_IDLE;
                    res.fault_values_reset = 1'b1;
                end
            end
            default:
            begin
                mode_next = mode_eff;
            end
        endcase

        res.mode          = mode_next;
        res.under_tripped = under_next;
        res.over_tripped  = over_next;
    end

    a_trip_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && res.run_values_reset) |=> (cnt_reg == '0 && mode_reg == MODE_IDLE))
        else $error("debounce counter not cleared on trip");

    a_fault_exit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && res.fault_values_reset) |-> (res.mode == MODE_IDLE && res.pwm_off))
        else $error("fault exit without idle mode");

    a_hold_without_step: assert property (@(posedge clk) disable iff (!rst_n)
        !step_en |=> ($stable(mode_reg) && $stable(cnt_reg) && $stable(under_reg)
                      && $stable(over_reg)))
        else $error("supervisor state moved without a tick");

    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && (res.reference_capture || res.normal_switching_request))
        |-> (res.mode == MODE_NORMAL && !res.pwm_off))
        else $error("start pulse without entry to normal");

endmodule

@@ src/pfc_line_supervisor_fsm.sv @@
// ----------------------------------------------------------------------------
// PFC line supervisor
// Per-tick supervisor of a power-factor-correction stage: start window,
// hysteresis on restart, debounced trips and fault hold-off.
// ----------------------------------------------------------------------------
// An accepted input beat passes through the input register, then the result
// register, before its result beat is offered.
// Throughput: one beat per cycle while out_ready is high; a tick is a single
// pass of compares and an 8-bit counter update between the two registers.
// Reset: asynchronous, active low; mode idle, trip flags and counter cleared,
// configuration registers take their documented defaults, no beat in flight.
// ----------------------------------------------------------------------------
module pfc_line_supervisor_fsm
    import pfcls_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,

    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t      cfg;
    out_item_t step_res;

    // Input register: holds one accepted beat until the result register has
    // room for its result.
    logic      in_vld_reg;
    logic      in_vld_next;
    in_item_t  in_data_reg;

    // Result register: parts the supervisor from the downstream stall, so a
    // new input beat can be taken while a finished result is still waiting.
    logic      out_vld_reg;
    logic      out_vld_next;
    out_item_t out_data_reg;

    // A tick is evaluated when a beat is waiting and its result can be stored.
    logic      advance;

    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_valid && in_ready)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (advance)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers carry no reset; their valid bits guard them.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= step_res;
        end
    end

    pfcls_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The state machine steps exactly once for every beat that moves into
    // the result register, so results keep the order of the input beats.
    pfcls_fsm u_fsm (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (in_data_reg),
        .cfg     (cfg),
        .res     (step_res)
    );

    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

    a_no_lost_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !advance) |=> in_vld_reg)
        else $error("held input beat dropped");

    a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out_ready && !advance) |=> (out_vld_reg && $stable(out_data_reg)))
        else $error("waiting result beat lost or altered");

    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !in_vld_reg |-> in_ready)
        else $error("input stalled with an empty input register");

endmodule
